// ----- rtl/core/rpsb_pkg.sv -----
// rpsb_pkg: shared types and constants for the rgb pixel store
// holds opcodes, register indexes, controller states and the command/status structs
// no dependencies
package rpsb_pkg;

    localparam int BYTE_W  = 8;
    localparam int PIXEL_W = 3 * BYTE_W;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int DIV_W   = 16;

    // operation codes of an input transaction
    typedef enum logic [1:0] {
        OP_SET = 2'd0,
        OP_GET = 2'd1,
        OP_BRT = 2'd2,
        OP_CLR = 2'd3
    } t_op;

    // configuration register indexes (word address)
    localparam logic [1:0] REG_RED   = 2'd0;
    localparam logic [1:0] REG_GREEN = 2'd1;
    localparam logic [1:0] REG_BLUE  = 2'd2;

    // reset values of the slot registers
    localparam logic [1:0] RED_SLOT_RST   = 2'd1;
    localparam logic [1:0] GREEN_SLOT_RST = 2'd0;
    localparam logic [1:0] BLUE_SLOT_RST  = 2'd2;

    // slot code that names no byte
    localparam logic [1:0] SLOT_NONE = 2'd3;

    // channel walk for a get
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // memory write data select
    typedef enum logic [1:0] {
        WS_ZERO  = 2'd0,
        WS_SET   = 2'd1,
        WS_SCALE = 2'd2
    } t_wsel;

    // divider operand select
    typedef enum logic {
        DS_CHAN   = 1'b0,
        DS_FACTOR = 1'b1
    } t_dsel;

    // controller states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_SET_WR,
        ST_GET_GO,
        ST_GET_WAIT,
        ST_FAC_WAIT,
        ST_SWP_RD,
        ST_SWP_WR,
        ST_CLR,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic  load_in;
        logic  mem_rd;
        logic  mem_wr;
        logic  addr_sweep;
        t_wsel wsel;
        logic  cnt_clr;
        logic  cnt_inc;
        logic  div_start;
        t_dsel dsel;
        logic  chan_clr;
        logic  chan_inc;
        logic  chan_store;
        logic  fac_store;
        logic  code_load;
        logic  out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  op;
        logic in_range;
        logic same_level;
        logic cnt_last;
        logic div_done;
        logic chan_last;
    } t_sts;

endpackage

// ----- rtl/core/rpsb_div.sv -----
// rpsb_div: restoring divider, one quotient bit per cycle
// 16-bit dividend by 8-bit divisor, done pulses in the cycle after the last step
// depends on rpsb_pkg
module rpsb_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [rpsb_pkg::DIV_W-1:0]      i_dividend,
    input  logic [rpsb_pkg::BYTE_W-1:0]     i_divisor,
    output logic                            o_done,
    output logic [rpsb_pkg::DIV_W-1:0]      o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [3:0]                    r_cnt;
    logic [rpsb_pkg::BYTE_W-1:0]   r_rem;
    logic [rpsb_pkg::DIV_W-1:0]    r_quo;

    logic [rpsb_pkg::BYTE_W:0]     trial;
    logic [rpsb_pkg::BYTE_W:0]     diff;
    logic                          ge;
    logic [rpsb_pkg::BYTE_W-1:0]   n_rem;

    // one restoring step: shift in the next dividend bit, try a subtract
    always_comb begin
        trial = {r_rem, r_quo[rpsb_pkg::DIV_W-1]};
        ge    = (trial >= {1'b0, i_divisor});
        diff  = trial - {1'b0, i_divisor};
        n_rem = ge ? diff[rpsb_pkg::BYTE_W-1:0] : trial[rpsb_pkg::BYTE_W-1:0];
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[rpsb_pkg::DIV_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/core/rpsb_dp.sv -----
// rpsb_dp: datapath of the pixel store
// pixel memory, slot registers, scaling multipliers, shared divider, result register
// depends on rpsb_pkg and rpsb_div
module rpsb_dp #(
    parameter int PIXEL_COUNT = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rpsb_pkg::t_cmd                  i_cmd,
    output rpsb_pkg::t_sts                  o_sts,
    input  logic [1:0]                      i_op,
    input  logic [15:0]                     i_pixel_index,
    input  logic [7:0]                      i_red,
    input  logic [7:0]                      i_green,
    input  logic [7:0]                      i_blue,
    input  logic [7:0]                      i_level,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rpsb_pkg::ADDR_W-1:0]     paddr,
    input  logic [rpsb_pkg::DATA_W-1:0]     pwdata,
    output logic [rpsb_pkg::DATA_W-1:0]     prdata,
    output logic [7:0]                      o_red_read,
    output logic [7:0]                      o_green_read,
    output logic [7:0]                      o_blue_read,
    output logic [7:0]                      o_level_now,
    output logic                            o_in_range
);

    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PIXEL_COUNT - 1);
    localparam int BW = rpsb_pkg::BYTE_W;
    localparam int PW = rpsb_pkg::PIXEL_W;
    localparam int DW = rpsb_pkg::DIV_W;

    // slot registers
    logic [1:0] r_slot_red;
    logic [1:0] r_slot_green;
    logic [1:0] r_slot_blue;

    // captured transaction
    rpsb_pkg::t_op r_op;
    logic [AW-1:0] r_idx;
    logic          r_in_range;
    logic [BW-1:0] r_red;
    logic [BW-1:0] r_green;
    logic [BW-1:0] r_blue;
    logic [BW-1:0] r_level;

    // working state
    logic [BW-1:0] r_code;
    logic [DW-1:0] r_factor;
    logic [AW-1:0] r_cnt;
    logic [1:0]    r_chan;
    logic [PW-1:0] r_rdata;
    logic [BW-1:0] r_res_red;
    logic [BW-1:0] r_res_green;
    logic [BW-1:0] r_res_blue;

    // result register
    logic [BW-1:0] r_out_red;
    logic [BW-1:0] r_out_green;
    logic [BW-1:0] r_out_blue;
    logic [BW-1:0] r_out_level;
    logic          r_out_range;

    logic [PW-1:0] mem [PIXEL_COUNT];

    logic [AW-1:0] addr;
    logic [PW-1:0] wdata;
    logic [PW-1:0] set_word;
    logic [PW-1:0] scale_word;
    logic [BW-1:0] n_code;
    logic [BW-1:0] old_code;
    logic [1:0]    chan_slot;
    logic [BW-1:0] chan_byte;
    logic [BW-1:0] chan_res;
    logic [2*BW-1:0] prod_red;
    logic [2*BW-1:0] prod_green;
    logic [2*BW-1:0] prod_blue;
    logic [BW-1:0] sc_red;
    logic [BW-1:0] sc_green;
    logic [BW-1:0] sc_blue;
    logic [DW+BW-1:0] prod_sw [3];
    logic [DW-1:0] div_dividend;
    logic [BW-1:0] div_divisor;
    logic          div_done;
    logic [DW-1:0] div_quo;
    logic          cfg_wr;
    logic          is_pixel_op;

    // configuration port
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_red   <= rpsb_pkg::RED_SLOT_RST;
            r_slot_green <= rpsb_pkg::GREEN_SLOT_RST;
            r_slot_blue  <= rpsb_pkg::BLUE_SLOT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                rpsb_pkg::REG_RED:   r_slot_red   <= pwdata[1:0];
                rpsb_pkg::REG_GREEN: r_slot_green <= pwdata[1:0];
                rpsb_pkg::REG_BLUE:  r_slot_blue  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            rpsb_pkg::REG_RED:   prdata = {30'd0, r_slot_red};
            rpsb_pkg::REG_GREEN: prdata = {30'd0, r_slot_green};
            rpsb_pkg::REG_BLUE:  prdata = {30'd0, r_slot_blue};
            default:             prdata = '0;
        endcase
    end

    // transaction capture; the flag only counts for set and get
    assign is_pixel_op = (rpsb_pkg::t_op'(i_op) == rpsb_pkg::OP_SET) ||
                         (rpsb_pkg::t_op'(i_op) == rpsb_pkg::OP_GET);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op       <= rpsb_pkg::t_op'(i_op);
            r_idx      <= i_pixel_index[AW-1:0];
            r_in_range <= is_pixel_op && ({1'b0, i_pixel_index} < 17'(PIXEL_COUNT));
            r_red      <= i_red;
            r_green    <= i_green;
            r_blue     <= i_blue;
            r_level    <= i_level;
        end
    end

    // brightness code
    assign n_code   = r_level + 8'd1;
    assign old_code = r_code - 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= '0;
        end else if (i_cmd.code_load) begin
            r_code <= n_code;
        end
    end

    // sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + AW'(1);
        end
    end

    // pixel memory, one access per cycle
    assign addr = i_cmd.addr_sweep ? r_cnt : r_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem[addr] <= wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= mem[addr];
        end
    end

    // set: scale the channels by the code
    always_comb begin
        prod_red   = 16'(r_red) * 16'(r_code);
        prod_green = 16'(r_green) * 16'(r_code);
        prod_blue  = 16'(r_blue) * 16'(r_code);
        sc_red     = (r_code == 8'd0) ? r_red   : prod_red[2*BW-1:BW];
        sc_green   = (r_code == 8'd0) ? r_green : prod_green[2*BW-1:BW];
        sc_blue    = (r_code == 8'd0) ? r_blue  : prod_blue[2*BW-1:BW];
    end

    // set: merge into the read pixel, red then green then blue
    always_comb begin
        set_word = r_rdata;
        if (r_slot_red != rpsb_pkg::SLOT_NONE) begin
            set_word[{r_slot_red, 3'b000} +: BW] = sc_red;
        end
        if (r_slot_green != rpsb_pkg::SLOT_NONE) begin
            set_word[{r_slot_green, 3'b000} +: BW] = sc_green;
        end
        if (r_slot_blue != rpsb_pkg::SLOT_NONE) begin
            set_word[{r_slot_blue, 3'b000} +: BW] = sc_blue;
        end
    end

    // brightness sweep: each byte times the factor, bits 15:8 kept
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod_sw[k] = 24'(r_rdata[k*BW +: BW]) * 24'(r_factor);
            scale_word[k*BW +: BW] = prod_sw[k][2*BW-1:BW];
        end
    end

    always_comb begin
        case (i_cmd.wsel)
            rpsb_pkg::WS_ZERO:  wdata = '0;
            rpsb_pkg::WS_SET:   wdata = set_word;
            rpsb_pkg::WS_SCALE: wdata = scale_word;
            default:            wdata = '0;
        endcase
    end

    // get: pick the byte of the current channel
    always_comb begin
        case (r_chan)
            rpsb_pkg::CH_RED:   chan_slot = r_slot_red;
            rpsb_pkg::CH_GREEN: chan_slot = r_slot_green;
            default:            chan_slot = r_slot_blue;
        endcase
        case (chan_slot)
            2'd0:    chan_byte = r_rdata[0*BW +: BW];
            2'd1:    chan_byte = r_rdata[1*BW +: BW];
            2'd2:    chan_byte = r_rdata[2*BW +: BW];
            default: chan_byte = '0;
        endcase
    end

    // shared divider: channel un-scale or rescale factor
    // level 255 wraps the new code to zero, so the dividend becomes 65535
    always_comb begin
        case (i_cmd.dsel)
            rpsb_pkg::DS_FACTOR: begin
                div_dividend = {n_code, 8'h00} - 16'd1;
                div_divisor  = old_code;
            end
            default: begin
                div_dividend = {chan_byte, 8'h00};
                div_divisor  = r_code;
            end
        endcase
    end

    rpsb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // saturate the quotient; an unscaled code passes the byte through
    assign chan_res = (r_code == 8'd0)            ? chan_byte :
                      (div_quo[DW-1:BW] != '0)    ? 8'hFF     : div_quo[BW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= rpsb_pkg::CH_RED;
        end else if (i_cmd.chan_clr) begin
            r_chan <= rpsb_pkg::CH_RED;
        end else if (i_cmd.chan_inc) begin
            r_chan <= r_chan + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_res_red   <= '0;
            r_res_green <= '0;
            r_res_blue  <= '0;
        end else if (i_cmd.chan_store) begin
            case (r_chan)
                rpsb_pkg::CH_RED:   r_res_red   <= chan_res;
                rpsb_pkg::CH_GREEN: r_res_green <= chan_res;
                default:            r_res_blue  <= chan_res;
            endcase
        end
    end

    // rescale factor, zero when the old level was zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.fac_store) begin
            r_factor <= (old_code == 8'd0) ? '0 : div_quo;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_red   <= r_res_red;
            r_out_green <= r_res_green;
            r_out_blue  <= r_res_blue;
            r_out_level <= r_code - 8'd1;
            r_out_range <= r_in_range;
        end
    end

    assign o_red_read   = r_out_red;
    assign o_green_read = r_out_green;
    assign o_blue_read  = r_out_blue;
    assign o_level_now  = r_out_level;
    assign o_in_range   = r_out_range;

    // status
    assign o_sts.op         = r_op;
    assign o_sts.in_range   = r_in_range;
    assign o_sts.same_level = (n_code == r_code);
    assign o_sts.cnt_last   = (r_cnt == LAST_ADDR);
    assign o_sts.div_done   = div_done;
    assign o_sts.chan_last  = (r_chan == rpsb_pkg::CH_BLUE);

endmodule

// ----- rtl/core/rpsb_ctrl.sv -----
// rpsb_ctrl: controller state machine of the pixel store
// sequences memory sweeps, divisions and the result handshake
// depends on rpsb_pkg
module rpsb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rpsb_pkg::t_sts    i_sts,
    output rpsb_pkg::t_cmd    o_cmd
);

    rpsb_pkg::t_state r_state;
    rpsb_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // state and result valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpsb_pkg::ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = rpsb_pkg::t_cmd'(0);
        o_in_ready = 1'b0;
        case (r_state)
            rpsb_pkg::ST_INIT: begin
                o_cmd.mem_wr     = 1'b1;
                o_cmd.addr_sweep = 1'b1;
                o_cmd.wsel       = rpsb_pkg::WS_ZERO;
                o_cmd.cnt_inc    = 1'b1;
                if (i_sts.cnt_last) begin
                    o_cmd.cnt_inc = 1'b0;
                    n_state       = rpsb_pkg::ST_IDLE;
                end
            end
            rpsb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = rpsb_pkg::ST_DECODE;
                end
            end
            rpsb_pkg::ST_DECODE: begin
                case (i_sts.op)
                    rpsb_pkg::OP_SET: begin
                        if (i_sts.in_range) begin
                            o_cmd.mem_rd = 1'b1;
                            n_state      = rpsb_pkg::ST_SET_WR;
                        end else begin
                            n_state = rpsb_pkg::ST_DONE;
                        end
                    end
                    rpsb_pkg::OP_GET: begin
                        if (i_sts.in_range) begin
                            o_cmd.mem_rd   = 1'b1;
                            o_cmd.chan_clr = 1'b1;
                            n_state        = rpsb_pkg::ST_GET_GO;
                        end else begin
                            n_state = rpsb_pkg::ST_DONE;
                        end
                    end
                    rpsb_pkg::OP_BRT: begin
                        if (i_sts.same_level) begin
                            n_state = rpsb_pkg::ST_DONE;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.dsel      = rpsb_pkg::DS_FACTOR;
                            n_state         = rpsb_pkg::ST_FAC_WAIT;
                        end
                    end
                    default: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = rpsb_pkg::ST_CLR;
                    end
                endcase
            end
            rpsb_pkg::ST_SET_WR: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.wsel   = rpsb_pkg::WS_SET;
                n_state      = rpsb_pkg::ST_DONE;
            end
            rpsb_pkg::ST_GET_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.dsel      = rpsb_pkg::DS_CHAN;
                n_state         = rpsb_pkg::ST_GET_WAIT;
            end
            rpsb_pkg::ST_GET_WAIT: begin
                o_cmd.dsel = rpsb_pkg::DS_CHAN;
                if (i_sts.div_done) begin
                    o_cmd.chan_store = 1'b1;
                    if (i_sts.chan_last) begin
                        n_state = rpsb_pkg::ST_DONE;
                    end else begin
                        o_cmd.chan_inc = 1'b1;
                        n_state        = rpsb_pkg::ST_GET_GO;
                    end
                end
            end
            rpsb_pkg::ST_FAC_WAIT: begin
                o_cmd.dsel = rpsb_pkg::DS_FACTOR;
                if (i_sts.div_done) begin
                    o_cmd.fac_store = 1'b1;
                    o_cmd.cnt_clr   = 1'b1;
                    n_state         = rpsb_pkg::ST_SWP_RD;
                end
            end
            rpsb_pkg::ST_SWP_RD: begin
                o_cmd.mem_rd     = 1'b1;
                o_cmd.addr_sweep = 1'b1;
                n_state          = rpsb_pkg::ST_SWP_WR;
            end
            rpsb_pkg::ST_SWP_WR: begin
                o_cmd.mem_wr     = 1'b1;
                o_cmd.addr_sweep = 1'b1;
                o_cmd.wsel       = rpsb_pkg::WS_SCALE;
                if (i_sts.cnt_last) begin
                    o_cmd.code_load = 1'b1;
                    n_state         = rpsb_pkg::ST_DONE;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = rpsb_pkg::ST_SWP_RD;
                end
            end
            rpsb_pkg::ST_CLR: begin
                o_cmd.mem_wr     = 1'b1;
                o_cmd.addr_sweep = 1'b1;
                o_cmd.wsel       = rpsb_pkg::WS_ZERO;
                if (i_sts.cnt_last) begin
                    n_state = rpsb_pkg::ST_DONE;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            rpsb_pkg::ST_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = rpsb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rpsb_pkg::ST_IDLE;
            end
        endcase
    end

    // result valid: set on load, cleared when the transaction is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/core/rgb_pixel_store_with_brightness.sv -----
// rgb_pixel_store_with_brightness: top level of the rgb pixel store
// joins rpsb_ctrl and rpsb_dp; depends on rpsb_pkg
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------------------
//  input     i_valid / o_ready      i_op i_pixel_index i_red i_green i_blue i_level
//  output    o_valid / i_ready      o_red_read o_green_read o_blue_read o_level_now
//                                   o_in_range
//  config    psel penable pwrite    paddr pwdata prdata pready (slots at 0, 4, 8)
//
// one transaction at a time; a get runs three 16-step divisions on the one
// shared divider, a clear writes zero to every pixel, and a brightness change
// runs one divide, then a read and a write per pixel
// after reset a clearing pass zeroes the pixel memory,
// o_ready stays low meanwhile; configuration writes are taken throughout
// a finished result sits in the output register, so the next transaction is
// accepted while it waits; only a second result stalls on i_ready
module rgb_pixel_store_with_brightness #(
    parameter int PIXEL_COUNT = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_op,
    input  logic [15:0]                     i_pixel_index,
    input  logic [7:0]                      i_red,
    input  logic [7:0]                      i_green,
    input  logic [7:0]                      i_blue,
    input  logic [7:0]                      i_level,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [7:0]                      o_red_read,
    output logic [7:0]                      o_green_read,
    output logic [7:0]                      o_blue_read,
    output logic [7:0]                      o_level_now,
    output logic                            o_in_range,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rpsb_pkg::ADDR_W-1:0]     paddr,
    input  logic [rpsb_pkg::DATA_W-1:0]     pwdata,
    output logic [rpsb_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    rpsb_pkg::t_cmd cmd;
    rpsb_pkg::t_sts sts;

    assign pready = 1'b1;

    // controller
    rpsb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath
    rpsb_dp #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_op),
        .i_pixel_index (i_pixel_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_level       (i_level),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .o_red_read    (o_red_read),
        .o_green_read  (o_green_read),
        .o_blue_read   (o_blue_read),
        .o_level_now   (o_level_now),
        .o_in_range    (o_in_range)
    );

    // an accepted transaction makes the block busy at once
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready
    ) else $error("input still ready after accepting a transaction");

    // nonzero read channels only come from an in-range get
    a_read_needs_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_red_read != 8'd0) || (o_green_read != 8'd0) ||
                     (o_blue_read != 8'd0))) |-> o_in_range
    ) else $error("read data on a result without an in-range pixel");

    // reset empties the output and starts the clearing pass
    a_reset_quiet: assert property (
        @(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_ready)
    ) else $error("output valid or input ready straight after reset");

endmodule
